@@ src/mep_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mep_pkg;

	typedef logic [1:0] dir_t;

	localparam dir_t DIR_N = 2'd0;
	localparam dir_t DIR_E = 2'd1;
	localparam dir_t DIR_S = 2'd2;
	localparam dir_t DIR_W = 2'd3;

	localparam logic [1:0] TURN_STRAIGHT = 2'd0;
	localparam logic [1:0] TURN_RIGHT    = 2'd1;
	localparam logic [1:0] TURN_LEFT     = 2'd2;
	localparam logic [1:0] TURN_BACK     = 2'd3;

	localparam logic [1:0] SIDE_LEFT  = 2'd0;
	localparam logic [1:0] SIDE_RIGHT = 2'd1;
	localparam logic [1:0] SIDE_FRONT = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int COORD_W    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_START_COL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_INIT,
		ST_IDLE,
		ST_POPW,
		ST_RD,
		ST_REC,
		ST_SRD,
		ST_SCHK,
		ST_POST,
		ST_GOALW,
		ST_CHK,
		ST_NB,
		ST_POPS,
		ST_SCLR,
		ST_PRD,
		ST_PSW,
		ST_EMIT
	} state_t;

	function automatic logic [1:0] turn_code(dir_t diff);
		logic [1:0] t;
		unique case (diff)
			2'd0: t = TURN_STRAIGHT;
			2'd1: t = TURN_RIGHT;
			2'd2: t = TURN_BACK;
			2'd3: t = TURN_LEFT;
		endcase
		return t;
	endfunction

	function automatic dir_t side_dir(dir_t h, logic [1:0] side);
		dir_t d;
		unique case (side)
			SIDE_LEFT:  d = h + 2'd3;
			SIDE_RIGHT: d = h + 2'd1;
			default:    d = h;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

@@ src/mep_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mep_arrival_if;
	import mep_pkg::*;
	logic valid;
	logic ready;
	logic wall_left;
	logic wall_right;
	logic wall_front;
	modport source (output valid, wall_left, wall_right, wall_front, input ready);
	modport sink (input valid, wall_left, wall_right, wall_front, output ready);
endinterface

interface mep_move_if;
	import mep_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         turn;
	dir_t               heading;
	logic [COORD_W-1:0] cur_col;
	logic [COORD_W-1:0] cur_row;
	logic               finished;
	modport source (output valid, turn, heading, cur_col, cur_row, finished, input ready);
	modport sink (input valid, turn, heading, cur_col, cur_row, finished, output ready);
endinterface

interface mep_cfg_if;
	import mep_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

@@ src/maze_exploration_planner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                                       handshake
// arrival   in   wall_left, wall_right, wall_front             valid/ready
// move      out  turn, heading, cur_col, cur_row, finished     valid/ready
// cfg       in   idx (0 col, 1 row, 2 heading), data           valid/ready
//
// One item at a time. When a new path is searched, an item also takes a depth-first
// walk over the cells reached, trying each open side, and a sweep of all
// 2**(2*clog2(GRID_SIZE)) entries of the search map. Reset and every accepted register
// write run a clearing pass over all entries of the cell and search maps; no arrival is
// taken meanwhile, register writes always are. The result sits in an output register;
// a stalled move channel holds the block in emit.
module maze_exploration_planner #(
	parameter int GRID_SIZE  = 16,
	parameter int FIFO_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	mep_arrival_if.sink   arrival,
	mep_move_if.source    move,
	mep_cfg_if.sink       cfg
);
	import mep_pkg::*;

	localparam int PW    = $clog2(GRID_SIZE);
	localparam int AW    = 2 * PW;
	localparam int MAPD  = 2 ** AW;
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int SW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int FW    = $clog2(FIFO_DEPTH);
	localparam int CW    = $clog2(FIFO_DEPTH + 1);
	localparam int STW   = AW + 7;

	typedef logic [AW-1:0] cell_t;

	function automatic logic nb_ok(cell_t c, dir_t d);
		logic [PW-1:0] r;
		logic [PW-1:0] k;
		logic ok;
		r = c[AW-1:PW];
		k = c[PW-1:0];
		unique case (d)
			DIR_N: ok = (r != PW'(GRID_SIZE - 1));
			DIR_E: ok = (k != PW'(GRID_SIZE - 1));
			DIR_S: ok = (r != '0);
			DIR_W: ok = (k != '0);
		endcase
		return ok;
	endfunction

	function automatic cell_t nb_cell(cell_t c, dir_t d);
		logic [PW-1:0] r;
		logic [PW-1:0] k;
		r = c[AW-1:PW];
		k = c[PW-1:0];
		unique case (d)
			DIR_N: r = r + PW'(1);
			DIR_E: k = k + PW'(1);
			DIR_S: r = r - PW'(1);
			DIR_W: k = k - PW'(1);
		endcase
		return {r, k};
	endfunction

	state_t state_q, state_d;

	logic [COORD_W-1:0] scol_q, srow_q;
	dir_t               shead_q;
	cell_t              pos_q;
	dir_t               heading_q;
	logic               following_q, done_q;
	logic [FW-1:0]      fhead_q;
	logic [CW-1:0]      fcount_q;
	logic [2:0]         wall_q;
	logic [3:0]         open_q;
	dir_t               next_dir_q;
	logic               fin_q;
	logic [1:0]         side_q;
	cell_t              goal_q;
	cell_t              top_cell_q;
	logic [2:0]         top_dir_q;
	logic [3:0]         top_open_q;
	logic [SW-1:0]      top_idx_q;
	cell_t              nb_q;
	logic [LW-1:0]      len_q, pidx_q;
	cell_t              clr_q;

	logic               out_valid_q;
	logic [1:0]         out_turn_q;
	dir_t               out_heading_q;
	logic [COORD_W-1:0] out_col_q, out_row_q;
	logic               out_fin_q;

	// memories
	logic [4:0]     cell_mem [MAPD];
	logic           cell_we;
	cell_t          cell_wa, cell_ra;
	logic [4:0]     cell_wd, cell_rd_q;

	logic           srch_mem [MAPD];
	logic           srch_we, srch_wd, srch_rd_q;
	cell_t          srch_wa, srch_ra;

	cell_t          fifo_mem [FIFO_DEPTH];
	logic           fifo_we;
	logic [FW-1:0]  fifo_wa;
	cell_t          fifo_wd, fifo_rd_q;

	dir_t           path_mem [CELLS];
	logic           path_we;
	dir_t           path_rd_q;

	logic [STW-1:0] stack_mem [CELLS];
	logic           stack_we;
	logic [SW-1:0]  stack_ra;
	logic [STW-1:0] stack_rd_q;

	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		cell_rd_q <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (srch_we) srch_mem[srch_wa] <= srch_wd;
		srch_rd_q <= srch_mem[srch_ra];
	end

	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
		fifo_rd_q <= fifo_mem[fhead_q];
	end

	always_ff @(posedge clk) begin
		if (path_we) path_mem[top_idx_q] <= top_dir_q[1:0];
		path_rd_q <= path_mem[pidx_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stack_we) stack_mem[top_idx_q] <= {top_cell_q, top_dir_q, top_open_q};
		stack_rd_q <= stack_mem[stack_ra];
	end

	// handshakes
	logic in_fire, out_free, cfg_hit, emit_load;
	assign cfg_hit  = cfg.valid && (cfg.idx == CFG_START_COL || cfg.idx == CFG_START_ROW
		|| cfg.idx == CFG_START_HEADING);
	// hold off an arrival while a register write restarts the block
	assign arrival.ready = (state_q == ST_IDLE) && !cfg_hit;
	assign in_fire  = arrival.valid && arrival.ready;
	assign out_free = !out_valid_q || move.ready;
	assign cfg.ready = 1'b1;
	assign emit_load = (state_q == ST_EMIT) && out_free && !cfg_hit;

	assign move.valid    = out_valid_q;
	assign move.turn     = out_turn_q;
	assign move.heading  = out_heading_q;
	assign move.cur_col  = out_col_q;
	assign move.cur_row  = out_row_q;
	assign move.finished = out_fin_q;

	// start cell, saturated onto the grid
	logic [PW-1:0] start_col, start_row;
	cell_t         start_cell, start_n;
	logic          start_n_ok;
	assign start_col  = (int'(scol_q) < GRID_SIZE) ? PW'(scol_q) : PW'(GRID_SIZE - 1);
	assign start_row  = (int'(srow_q) < GRID_SIZE) ? PW'(srow_q) : PW'(GRID_SIZE - 1);
	assign start_cell = {start_row, start_col};
	assign start_n_ok = nb_ok(start_cell, DIR_N);
	assign start_n    = nb_cell(start_cell, DIR_N);

	// recording of the current cell
	logic [3:0] rec_open;
	dir_t       rec_next;
	always_comb begin
		dir_t rd;
		dir_t d;
		rd = heading_q + 2'd2;
		rec_open = cell_rd_q[3:0];
		rec_next = rd;
		if (nb_ok(pos_q, rd)) rec_open[rd] = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d = side_dir(heading_q, 2'(i));
			if (!wall_q[i] && nb_ok(pos_q, d)) begin
				rec_open[d] = 1'b1;
				rec_next = d;
			end
		end
	end

	dir_t  side_d;
	logic  side_free;
	cell_t side_n;
	assign side_d    = side_dir(heading_q, side_q);
	assign side_free = !wall_q[side_q] && nb_ok(pos_q, side_d);
	assign side_n    = nb_cell(pos_q, side_d);

	dir_t  top_d;
	logic  chk_ok;
	cell_t chk_n;
	assign top_d  = top_dir_q[1:0];
	assign chk_ok = top_open_q[top_d] && nb_ok(top_cell_q, top_d);
	assign chk_n  = nb_cell(top_cell_q, top_d);

	logic          fwd_ok;
	assign fwd_ok = nb_ok(pos_q, heading_q);

	logic [FW:0]   tail_sum;
	logic [FW-1:0] tail, head_next;
	logic          fifo_empty, fifo_full;
	assign tail_sum   = {1'b0, fhead_q} + (FW + 1)'(fcount_q);
	assign tail       = (tail_sum >= (FW + 1)'(FIFO_DEPTH)) ?
		FW'(tail_sum - (FW + 1)'(FIFO_DEPTH)) : FW'(tail_sum);
	assign head_next  = (fhead_q == FW'(FIFO_DEPTH - 1)) ? '0 : fhead_q + FW'(1);
	assign fifo_empty = (fcount_q == '0);
	assign fifo_full  = (fcount_q >= CW'(FIFO_DEPTH));

	logic clr_last, push_ok, stack_room;
	assign clr_last   = (clr_q == '1);
	assign push_ok    = !cell_rd_q[4] && !fifo_full;
	assign stack_room = (top_idx_q < SW'(CELLS - 1));
	assign stack_ra   = top_idx_q - SW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:   if (clr_last) state_d = ST_INIT;
			ST_INIT:  state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_fire) begin
					if (done_q) state_d = ST_EMIT;
					else if (!following_q) state_d = fifo_empty ? ST_EMIT : ST_POPW;
					else state_d = ST_RD;
				end
			end
			ST_POPW:  state_d = ST_RD;
			ST_RD:    state_d = ST_REC;
			ST_REC:   state_d = cell_rd_q[4] ? ST_POST : ST_SRD;
			ST_SRD: begin
				if (side_free) state_d = ST_SCHK;
				else if (side_q == SIDE_FRONT) state_d = ST_POST;
			end
			ST_SCHK:  state_d = (side_q == SIDE_FRONT) ? ST_POST : ST_SRD;
			ST_POST: begin
				if (following_q) state_d = ST_PRD;
				else state_d = fifo_empty ? ST_EMIT : ST_GOALW;
			end
			ST_GOALW: state_d = (fifo_rd_q == pos_q) ? ST_EMIT : ST_CHK;
			ST_CHK: begin
				if (top_dir_q[2]) state_d = (top_idx_q == '0) ? ST_SCLR : ST_POPS;
				else if (chk_ok) state_d = ST_NB;
			end
			ST_NB: begin
				if (!srch_rd_q && nb_q == goal_q) state_d = ST_SCLR;
				else state_d = ST_CHK;
			end
			ST_POPS:  state_d = ST_CHK;
			ST_SCLR:  if (clr_last) state_d = (len_q != '0) ? ST_PRD : ST_EMIT;
			ST_PRD:   state_d = ST_PSW;
			ST_PSW:   state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLR;
		endcase
		if (cfg_hit) state_d = ST_CLR;
	end

	// memory controls
	always_comb begin
		cell_we  = 1'b0;
		cell_wa  = clr_q;
		cell_wd  = '0;
		cell_ra  = pos_q;
		srch_we  = 1'b0;
		srch_wa  = clr_q;
		srch_wd  = 1'b0;
		srch_ra  = chk_n;
		fifo_we  = 1'b0;
		fifo_wa  = tail;
		fifo_wd  = side_n;
		path_we  = 1'b0;
		stack_we = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cell_we = 1'b1;
				srch_we = 1'b1;
			end
			ST_INIT: begin
				cell_we = 1'b1;
				cell_wa = start_cell;
				cell_wd = {1'b1, 3'b000, start_n_ok};
				fifo_we = start_n_ok;
				fifo_wa = '0;
				fifo_wd = start_n;
			end
			ST_REC: begin
				cell_we = 1'b1;
				cell_wa = pos_q;
				cell_wd = {1'b1, rec_open};
			end
			ST_SRD:  cell_ra = side_n;
			ST_SCHK: fifo_we = push_ok;
			ST_GOALW: begin
				srch_we = (fifo_rd_q != pos_q);
				srch_wa = pos_q;
				srch_wd = 1'b1;
			end
			ST_CHK: begin
				cell_ra = chk_n;
				path_we = !top_dir_q[2] && chk_ok;
			end
			ST_NB: begin
				if (!srch_rd_q) begin
					srch_we  = 1'b1;
					srch_wa  = nb_q;
					srch_wd  = 1'b1;
					stack_we = (nb_q != goal_q) && stack_room;
				end
			end
			ST_SCLR: srch_we = 1'b1;
			default: begin
			end
		endcase
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			scol_q        <= '0;
			srow_q        <= '0;
			shead_q       <= DIR_N;
			pos_q         <= '0;
			heading_q     <= DIR_N;
			following_q   <= 1'b0;
			done_q        <= 1'b0;
			fhead_q       <= '0;
			fcount_q      <= '0;
			wall_q        <= '0;
			open_q        <= '0;
			next_dir_q    <= DIR_N;
			fin_q         <= 1'b0;
			side_q        <= SIDE_LEFT;
			goal_q        <= '0;
			top_cell_q    <= '0;
			top_dir_q     <= '0;
			top_open_q    <= '0;
			top_idx_q     <= '0;
			nb_q          <= '0;
			len_q         <= '0;
			pidx_q        <= '0;
			clr_q         <= '0;
			out_valid_q   <= 1'b0;
			out_turn_q    <= TURN_STRAIGHT;
			out_heading_q <= DIR_N;
			out_col_q     <= '0;
			out_row_q     <= '0;
			out_fin_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_load) out_valid_q <= 1'b1;
			else if (move.valid && move.ready) out_valid_q <= 1'b0;
			if (cfg_hit) begin
				unique case (cfg.idx)
					CFG_START_COL: scol_q <= cfg.data;
					CFG_START_ROW: srow_q <= cfg.data;
					default:       shead_q <= cfg.data[1:0];
				endcase
				clr_q <= '0;
			end else begin
				unique case (state_q)
					ST_CLR: clr_q <= clr_q + AW'(1);
					ST_INIT: begin
						pos_q       <= start_cell;
						heading_q   <= shead_q;
						done_q      <= 1'b0;
						following_q <= 1'b0;
						fhead_q     <= '0;
						fcount_q    <= CW'(start_n_ok);
						len_q       <= '0;
						pidx_q      <= '0;
					end
					ST_IDLE: begin
						if (in_fire) begin
							wall_q     <= {arrival.wall_front, arrival.wall_right,
								arrival.wall_left};
							fin_q      <= 1'b0;
							next_dir_q <= heading_q;
							if (done_q) begin
								fin_q <= 1'b1;
							end else if (!following_q) begin
								if (fifo_empty) begin
									done_q <= 1'b1;
									fin_q  <= 1'b1;
								end
							end else if (fwd_ok) begin
								pos_q <= nb_cell(pos_q, heading_q);
							end
						end
					end
					ST_POPW: begin
						pos_q    <= fifo_rd_q;
						fhead_q  <= head_next;
						fcount_q <= fcount_q - CW'(1);
					end
					ST_REC: begin
						open_q     <= rec_open;
						next_dir_q <= rec_next;
						side_q     <= SIDE_LEFT;
					end
					ST_SRD: if (!side_free) side_q <= side_q + 2'd1;
					ST_SCHK: begin
						if (push_ok) fcount_q <= fcount_q + CW'(1);
						side_q <= side_q + 2'd1;
					end
					ST_POST: begin
						if (!following_q && fifo_empty) begin
							done_q     <= 1'b1;
							fin_q      <= 1'b1;
							next_dir_q <= heading_q;
						end
					end
					ST_GOALW: begin
						goal_q     <= fifo_rd_q;
						len_q      <= '0;
						pidx_q     <= '0;
						top_cell_q <= pos_q;
						top_dir_q  <= '0;
						top_open_q <= open_q;
						top_idx_q  <= '0;
					end
					ST_CHK: begin
						if (top_dir_q[2]) begin
							// drop the exhausted top entry
							if (top_idx_q == '0) clr_q <= '0;
							else top_idx_q <= top_idx_q - SW'(1);
						end else begin
							top_dir_q <= top_dir_q + 3'd1;
							nb_q      <= chk_n;
						end
					end
					ST_NB: begin
						if (!srch_rd_q) begin
							if (nb_q == goal_q) begin
								len_q <= LW'(top_idx_q) + LW'(1);
								clr_q <= '0;
							end else if (stack_room) begin
								top_cell_q <= nb_q;
								top_dir_q  <= '0;
								top_open_q <= cell_rd_q[3:0];
								top_idx_q  <= top_idx_q + SW'(1);
							end
						end
					end
					ST_POPS: {top_cell_q, top_dir_q, top_open_q} <= stack_rd_q;
					ST_SCLR: clr_q <= clr_q + AW'(1);
					ST_PSW: begin
						next_dir_q <= path_rd_q;
						if (pidx_q + LW'(1) >= len_q) begin
							following_q <= 1'b0;
							pidx_q      <= '0;
						end else begin
							following_q <= 1'b1;
							pidx_q      <= pidx_q + LW'(1);
						end
					end
					ST_EMIT: begin
						if (out_free) begin
							out_turn_q    <= fin_q ? TURN_STRAIGHT :
								turn_code(next_dir_q - heading_q);
							out_heading_q <= next_dir_q;
							heading_q     <= next_dir_q;
							out_col_q     <= COORD_W'(pos_q[PW-1:0]);
							out_row_q     <= COORD_W'(pos_q[AW-1:PW]);
							out_fin_q     <= fin_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

@@ verif/tb_maze_exploration_planner.sv @@
`timescale 1ns / 1ps
module tb_maze_exploration_planner;
	import mep_pkg::*;

	localparam int GRID  = 16;
	localparam int CELLS = GRID * GRID;
	localparam int FDEP  = 64;
	localparam int WATCHDOG = 200000;

	typedef struct packed {
		logic [1:0] turn;
		dir_t       heading;
		logic [3:0] col;
		logic [3:0] row;
		logic       finished;
	} move_t;

	class move_scoreboard;
		move_t pending[$];
		int    fails;

		// planner state
		logic [3:0] st_col, st_row;
		dir_t       st_head;
		logic [3:0] open_bits[CELLS];
		bit         explored[CELLS];
		int         frontier[FDEP];
		int         f_head, f_count;
		dir_t       route[CELLS];
		int         route_len, route_idx;
		int         pos;
		dir_t       head;
		bit         on_route, done;

		function bit step_to(int c, dir_t d, output int n);
			int col, row;
			col = c % GRID;
			row = c / GRID;
			case (d)
				DIR_N: begin if (row + 1 >= GRID) return 0; row++; end
				DIR_E: begin if (col + 1 >= GRID) return 0; col++; end
				DIR_S: begin if (row == 0) return 0; row--; end
				default: begin if (col == 0) return 0; col--; end
			endcase
			n = row * GRID + col;
			return 1;
		endfunction

		function void enqueue(int c);
			if (f_count >= FDEP) return;
			frontier[(f_head + f_count) % FDEP] = c;
			f_count++;
		endfunction

		function void restart();
			int n;
			foreach (open_bits[i]) open_bits[i] = 0;
			foreach (explored[i]) explored[i] = 0;
			f_head = 0; f_count = 0;
			route_len = 0; route_idx = 0;
			on_route = 0; done = 0;
			pos = int'(st_row) * GRID + int'(st_col);
			head = st_head;
			explored[pos] = 1;
			if (step_to(pos, DIR_N, n)) begin
				open_bits[pos][DIR_N] = 1'b1;
				enqueue(n);
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
			case (idx)
				CFG_START_COL: st_col = val;
				CFG_START_ROW: st_row = val;
				CFG_START_HEADING: st_head = val[1:0];
				default: return;
			endcase
			restart();
		endfunction

		function int find_route(int src, int goal);
			bit   seen[CELLS];
			int   cell_stk[CELLS];
			int   dir_stk[CELLS];
			int   sp, top, c, d, n;
			if (src == goal) return 0;
			seen[src] = 1;
			cell_stk[0] = src;
			dir_stk[0] = 0;
			sp = 1;
			while (sp > 0) begin
				top = sp - 1;
				c = cell_stk[top];
				d = dir_stk[top];
				if (d >= 4) begin
					sp--;
					continue;
				end
				dir_stk[top] = d + 1;
				if (!open_bits[c][d] || !step_to(c, dir_t'(d), n)) continue;
				route[top] = dir_t'(d);
				if (seen[n]) continue;
				seen[n] = 1;
				if (n == goal) return top + 1;
				if (sp < CELLS) begin
					cell_stk[sp] = n;
					dir_stk[sp] = 0;
					sp++;
				end
			end
			return 0;
		endfunction

		function void push_result(logic [1:0] t, bit fin);
			move_t m;
			m.turn = t;
			m.heading = head;
			m.col = 4'(pos % GRID);
			m.row = 4'(pos / GRID);
			m.finished = fin;
			pending.push_back(m);
		endfunction

		function void note_arrival(logic wl, logic wr, logic wf);
			logic [2:0] walls;
			dir_t       nxt, d, diff;
			bit         fresh;
			int         n;
			walls = {wf, wr, wl};
			if (done) begin
				push_result(TURN_STRAIGHT, 1);
				return;
			end
			if (!on_route) begin
				if (f_count == 0) begin
					done = 1;
					push_result(TURN_STRAIGHT, 1);
					return;
				end
				pos = frontier[f_head];
				f_head = (f_head + 1) % FDEP;
				f_count--;
			end else if (step_to(pos, head, n)) begin
				pos = n;
			end
			fresh = !explored[pos];
			nxt = head + 2'd2;
			if (step_to(pos, nxt, n)) open_bits[pos][nxt] = 1'b1;
			for (int s = 0; s < 3; s++) begin
				d = side_dir(head, s[1:0]);
				if (walls[s]) continue;
				if (!step_to(pos, d, n)) continue;
				open_bits[pos][d] = 1'b1;
				nxt = d;
				if (fresh && !explored[n]) enqueue(n);
			end
			explored[pos] = 1;
			if (!on_route) begin
				if (f_count == 0) begin
					done = 1;
					push_result(TURN_STRAIGHT, 1);
					return;
				end
				route_len = find_route(pos, frontier[f_head]);
				route_idx = 0;
				if (route_len > 1) begin
					on_route = 1;
					nxt = route[0];
					route_idx = 1;
				end else if (route_len == 1) begin
					nxt = route[0];
				end
			end else begin
				nxt = route[route_idx];
				route_idx++;
				if (route_idx >= route_len) begin
					on_route = 0;
					route_idx = 0;
				end
			end
			diff = nxt - head;
			head = nxt;
			push_result(turn_code(diff), 0);
		endfunction

		function void check_move(move_t got);
			move_t want;
			if (pending.size() == 0) begin
				$error("unexpected move item %p", got);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (got.turn !== want.turn) begin
				$error("turn: expected %0d, got %0d", want.turn, got.turn); fails++;
			end
			if (got.heading !== want.heading) begin
				$error("heading: expected %0d, got %0d", want.heading, got.heading); fails++;
			end
			if (got.col !== want.col) begin
				$error("cur_col: expected %0d, got %0d", want.col, got.col); fails++;
			end
			if (got.row !== want.row) begin
				$error("cur_row: expected %0d, got %0d", want.row, got.row); fails++;
			end
			if (got.finished !== want.finished) begin
				$error("finished: expected %0d, got %0d", want.finished, got.finished);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	mep_arrival_if arrival();
	mep_move_if    move();
	mep_cfg_if     cfg();

	maze_exploration_planner #(.GRID_SIZE(GRID), .FIFO_DEPTH(FDEP)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.arrival(arrival.sink),
		.move(move.source),
		.cfg(cfg.sink)
	);

	move_scoreboard planner_sb;
	int  idle_cycles;
	bit  hold_ready;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// valid stays high into the next item when there is no gap
	task automatic send_arrival(logic [2:0] walls);
		int g;
		g = gap_len();
		if (g > 0) begin
			arrival.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		arrival.valid <= 1'b1;
		arrival.wall_left <= walls[0];
		arrival.wall_right <= walls[1];
		arrival.wall_front <= walls[2];
		do @(posedge clk); while (!arrival.ready);
		planner_sb.note_arrival(walls[0], walls[1], walls[2]);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
		cfg.valid <= 1'b1;
		cfg.idx <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		planner_sb.write_reg(idx, val);
	endtask

	task automatic drain();
		arrival.valid <= 1'b0;
		while (planner_sb.pending.size() != 0) @(posedge clk);
		// let any search finish plus a clearing sweep
		repeat (400) @(posedge clk);
	endtask

	task automatic explore_run(int n_items, int good_pct);
		logic [2:0] w;
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < good_pct) w = 3'($urandom_range(0, 7));
			else w = 3'b111;
			send_arrival(w);
		end
	endtask

	// result side: random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move.ready <= 1'b0;
		end else begin
			if (move.valid && move.ready)
				planner_sb.check_move({move.turn, move.heading, move.cur_col,
					move.cur_row, move.finished});
			if (hold_ready)
				move.ready <= 1'b1;
			else
				move.ready <= ($urandom_range(0, 99) < 70) ||
					($urandom_range(0, 99) < 50 && move.ready);
		end
	end

	always @(posedge clk) begin
		if ((arrival.valid && arrival.ready) || (move.valid && move.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		planner_sb = new();
		planner_sb.st_col = 0;
		planner_sb.st_row = 0;
		planner_sb.st_head = DIR_N;
		planner_sb.restart();
		idle_cycles = 0;
		hold_ready = 0;
		arst_n = 0;
		arrival.valid = 0;
		arrival.wall_left = 0;
		arrival.wall_right = 0;
		arrival.wall_front = 0;
		cfg.valid = 0;
		cfg.idx = CFG_START_COL;
		cfg.data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every wall pattern from the reset corner, until finished
		for (int w = 0; w < 8; w++) send_arrival(w[2:0]);
		send_arrival(3'b000);
		send_arrival(3'b111);
		drain();
		// opposite corner, facing west; top row means north is off grid
		write_cfg(CFG_START_COL, 4'd15);
		write_cfg(CFG_START_ROW, 4'd15);
		write_cfg(CFG_START_HEADING, 4'(DIR_W));
		cfg.valid <= 1'b0;
		send_arrival(3'b000);
		send_arrival(3'b000);
		drain();
		write_cfg(CFG_START_ROW, 4'd14);
		write_cfg(CFG_START_HEADING, 4'(DIR_S));
		cfg.valid <= 1'b0;
		for (int k = 0; k < 8; k++) send_arrival(3'b000);
		// keep move ready high, with no stalls, until every result is in
		hold_ready = 1;
		drain();
		hold_ready = 0;

		for (int ph = 0; ph < 12; ph++) begin
			write_cfg(CFG_START_COL, 4'($urandom_range(0, 15)));
			write_cfg(CFG_START_ROW, 4'($urandom_range(0, 14)));
			write_cfg(CFG_START_HEADING, 4'($urandom_range(0, 3)));
			cfg.valid <= 1'b0;
			explore_run(80, 90);
			drain();
		end

		if (planner_sb.fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
src/mep_pkg.sv
src/mep_ifs.sv
src/maze_exploration_planner.sv
verif/tb_maze_exploration_planner.sv
